[design/bvh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bvh_pkg
// Shared types and constants of the byte value histogram block.
// ----------------------------------------------------------------------------
package bvh_pkg;

  // Counter store geometry
  localparam int NumBins   = 256;
  localparam int AddrWidth = $clog2(NumBins);
  localparam int CountWidth = 40;

  // Result field width on the stream port
  localparam int FieldWidth = 40;

  // Stream port widths (tdata padded to whole bytes)
  localparam int InDataWidth  = 8;
  localparam int InUserWidth  = 2;
  localparam int OutBits      = 2 * FieldWidth + 1;
  localparam int OutDataWidth = ((OutBits + 7) / 8) * 8;

  // Top value of a counter
  localparam logic [CountWidth-1:0] CountTop = {CountWidth{1'b1}};

  // Item function codes; the unused code behaves as a query
  typedef enum logic [1:0] {
    FUNC_COUNT = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the item and read its bin
    logic commit;  // update the store and load the result register
  } cmd_t;

endpackage : bvh_pkg
`default_nettype wire

[design/bvh_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bvh_ctrl
// Controller: sequences one item through read and update, and owns the
// result valid flag of the output register.
// ----------------------------------------------------------------------------
module bvh_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output bvh_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   slot_free;

  // Result register may be refilled when empty or drained this cycle
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Track the result register occupancy
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule : bvh_ctrl
`default_nettype wire

[design/bvh_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bvh_dp
// Datapath: counter memory with per-bin valid bits, saturating increment,
// running maximum and the result register.
// ----------------------------------------------------------------------------
module bvh_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire bvh_pkg::cmd_t                       cmd,
  input  wire logic [bvh_pkg::InUserWidth-1:0]     in_func,
  input  wire logic [bvh_pkg::AddrWidth-1:0]       in_addr,
  output logic [bvh_pkg::FieldWidth-1:0]           bin_count,
  output logic [bvh_pkg::FieldWidth-1:0]           max_count,
  output logic                                     saturated
);

  logic [bvh_pkg::CountWidth-1:0] mem [bvh_pkg::NumBins];
  logic [bvh_pkg::NumBins-1:0]    valid;

  bvh_pkg::func_t                 func_q;
  logic [bvh_pkg::AddrWidth-1:0]  addr_q;
  logic [bvh_pkg::CountWidth-1:0] rd_data;
  logic                           rd_valid;
  logic [bvh_pkg::CountWidth-1:0] running_max;

  logic [bvh_pkg::CountWidth-1:0] cur;
  logic                           cur_top;
  logic [bvh_pkg::CountWidth-1:0] upd;
  logic [bvh_pkg::CountWidth-1:0] max_next;
  logic                           wr_en;
  logic                           clr_en;

  // Capture the item and read its bin
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q   <= bvh_pkg::func_t'(in_func);
      addr_q   <= in_addr;
      rd_data  <= mem[in_addr];
      rd_valid <= valid[in_addr];
    end
    if (wr_en) begin
      mem[addr_q] <= upd;
    end
  end

  // A bin never written since reset or clear reads as zero
  assign cur     = rd_valid ? rd_data : '0;
  assign cur_top = (cur == bvh_pkg::CountTop);

  // Compute the updated bin and maximum
  always_comb begin
    upd      = cur;
    max_next = running_max;
    wr_en    = 1'b0;
    clr_en   = 1'b0;
    case (func_q)
      bvh_pkg::FUNC_COUNT: begin
        upd      = cur_top ? cur : cur + 1'b1;
        max_next = (upd > running_max) ? upd : running_max;
        wr_en    = cmd.commit;
      end
      bvh_pkg::FUNC_CLEAR: begin
        upd      = '0;
        max_next = '0;
        clr_en   = cmd.commit;
      end
      default: begin
        upd      = cur;
        max_next = running_max;
      end
    endcase
  end

  // Valid bits and running maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      running_max <= '0;
    end else if (clr_en) begin
      valid       <= '0;
      running_max <= '0;
    end else if (cmd.commit) begin
      running_max <= max_next;
      if (wr_en) begin
        valid[addr_q] <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      bin_count <= bvh_pkg::FieldWidth'(upd);
      max_count <= bvh_pkg::FieldWidth'(max_next);
      saturated <= (upd == bvh_pkg::CountTop);
    end
  end

endmodule : bvh_dp
`default_nettype wire

[design/byte_value_histogram_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_value_histogram_top
// 256-bin byte value histogram with saturating counters and running maximum.
//
// Input stream: s_axis_tdata carries the byte (or bin index), s_axis_tuser
// the function: count, query or clear. Every transaction yields one result
// transaction on m_axis: the addressed counter after the item, the largest
// counter over all bins and a saturation flag.
// The result is registered: the counter memory is read in the accept cycle
// and written in the update cycle, one item at a time; the next item is
// accepted only after the update of the last one.
// A clear takes the same steps: per-bin valid bits are dropped at once.
// Reset clears all counters and the maximum immediately; no sweep follows.
// When the receiver stalls, one finished result waits in the output register
// while the next item is accepted; that item then waits in its update step
// until the register drains.
// ----------------------------------------------------------------------------
module byte_value_histogram_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // [7:0] data_byte
  input  wire logic [bvh_pkg::InDataWidth-1:0]      s_axis_tdata,
  // [1:0] func
  input  wire logic [bvh_pkg::InUserWidth-1:0]      s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // [39:0] bin_count, [79:40] max_count, [80] saturated, [87:81] zero
  output logic [bvh_pkg::OutDataWidth-1:0]          m_axis_tdata
);

  bvh_pkg::cmd_t                   cmd;
  logic [bvh_pkg::FieldWidth-1:0]  bin_count;
  logic [bvh_pkg::FieldWidth-1:0]  max_count;
  logic                            saturated;

  bvh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  bvh_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_func   (s_axis_tuser),
    .in_addr   (s_axis_tdata[bvh_pkg::AddrWidth-1:0]),
    .bin_count (bin_count),
    .max_count (max_count),
    .saturated (saturated)
  );

  // Pack result fields, lowest field first, zero padded
  assign m_axis_tdata = bvh_pkg::OutDataWidth'({saturated, max_count, bin_count});

endmodule : byte_value_histogram_top
`default_nettype wire
